// File: rtl/rba_pkg.sv
// Shared types and constants for the region bump allocator.
// Used by rba_cell, rba_ctrl and region_bump_allocator_unit; depends on nothing.
`timescale 1ns / 1ps

package rba_pkg;

  localparam int ADDR_W  = 32;
  localparam int PAGES_W = 21;
  localparam logic [PAGES_W-1:0] PAGES_MAX = '1;

  // request opcodes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic {
    CFG_POOL_BASE  = 1'b0,
    CFG_POOL_BYTES = 1'b1
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_t;

  // broadcast control from the sequencer to every table cell
  typedef struct packed {
    logic              start;    // inject token into the first cell
    logic              run;      // advance token along the chain
    logic              walk;     // token cell compares and shifts
    logic              shift;    // hit already seen: cells pull from next cell
    logic              wr_en;    // write new entry at wr_idx
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] wr_start;
    logic [PAGES_W-1:0] wr_pages;
  } cell_ctl_t;

endpackage

// File: rtl/rba_cell.sv
// One table entry of the region bump allocator: base, page count and walk token.
// Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_cell #(
  parameter int IDX_W = 5,
  parameter int IDX   = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rba_pkg::cell_ctl_t          ctl,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic                        tok_in,
  input  logic                        nxt_tok,
  input  logic [rba_pkg::ADDR_W-1:0]  nxt_start,
  input  logic [rba_pkg::PAGES_W-1:0] nxt_pages,
  output logic                        tok_out,
  output logic [rba_pkg::ADDR_W-1:0]  start_out,
  output logic [rba_pkg::PAGES_W-1:0] pages_out,
  output logic                        match,
  output logic [rba_pkg::ADDR_W-1:0]  tap_start,
  output logic [rba_pkg::PAGES_W-1:0] tap_pages
);
  import rba_pkg::*;

  logic               tok_r;
  logic [ADDR_W-1:0]  start_r;
  logic [PAGES_W-1:0] pages_r;

  // pass the token to the next cell while the walk runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= ctl.run & tok_in;
    end
  end

  // write a new entry, or pull the neighbor down once the hit lies behind
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (wr_idx == IDX_W'(IDX))) begin
      start_r <= ctl.wr_start;
      pages_r <= ctl.wr_pages;
    end else if (ctl.walk && ctl.shift && nxt_tok) begin
      start_r <= nxt_start;
      pages_r <= nxt_pages;
    end
  end

  // compare and expose the entry only while holding the token
  assign match     = ctl.walk & tok_r & (start_r == ctl.target);
  assign tap_start = tok_r ? start_r : '0;
  assign tap_pages = tok_r ? pages_r : '0;
  assign tok_out   = tok_r;
  assign start_out = start_r;
  assign pages_out = pages_r;

endmodule

// File: rtl/rba_ctrl.sv
// Sequencer of the region bump allocator: pool registers, entry count, tail
// address, table walk for release, and the result register. Depends on rba_pkg.
`timescale 1ns / 1ps

module rba_ctrl #(
  parameter int MAX_ENTRIES = 32,
  parameter int PAGE_BYTES  = 4096,
  parameter int IDX_W       = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic                        cfg_index,
  input  logic [rba_pkg::ADDR_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [rba_pkg::ADDR_W-1:0]  in_request_bytes,
  input  logic [rba_pkg::ADDR_W-1:0]  in_target_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [rba_pkg::ADDR_W-1:0]  out_region_address,
  output logic [20:0]                 out_released_pages,
  output logic                        out_inside_pool,
  output rba_pkg::cell_ctl_t          ctl,
  output logic [IDX_W-1:0]            wr_idx,
  input  logic [MAX_ENTRIES-1:0]      match_vec,
  input  logic [rba_pkg::ADDR_W-1:0]  tap_start [MAX_ENTRIES],
  input  logic [rba_pkg::PAGES_W-1:0] tap_pages [MAX_ENTRIES]
);
  import rba_pkg::*;

  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // byte span of a page count, modulo 2^32
  function automatic logic [ADDR_W-1:0] span_of(input logic [PAGES_W-1:0] pages);
    logic [63:0] ext;
    ext = 64'(pages) << PAGE_SHIFT;
    return ext[ADDR_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [1:0]          op_r;
  logic [ADDR_W-1:0]   bytes_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ADDR_W-1:0]   pool_base_r;
  logic [ADDR_W-1:0]   pool_bytes_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ADDR_W-1:0]   tail_r, tail_nxt;
  logic [IDX_W-1:0]    step_r;
  logic                found_r, found_nxt;
  logic [ADDR_W-1:0]   prev_end_r;
  logic [PAGES_W-1:0]  hit_pages_r, hit_pages_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [PAGES_W-1:0]  res_pages_r, res_pages_nxt;
  logic                res_inside_r, res_inside_nxt;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [PAGES_W-1:0]  out_pages_r;
  logic                out_inside_r;

  logic                in_fire;
  logic                out_free;
  logic                last_step;
  logic                any_match;
  logic [ADDR_W-1:0]   sel_start;
  logic [PAGES_W-1:0]  sel_pages;
  logic [ADDR_W-1:0]   sel_end;
  logic [ADDR_W:0]     round_sum;
  logic [ADDR_W:0]     round_pages;
  logic [PAGES_W-1:0]  alloc_pages;
  logic [ADDR_W-1:0]   alloc_addr;
  logic [ADDR_W:0]     pool_end;
  logic                alloc_ok;
  logic                release_go;

  assign in_fire  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // select the entry that holds the token
  always_comb begin
    any_match = |match_vec;
    sel_start = '0;
    sel_pages = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      sel_start = sel_start | tap_start[i];
      sel_pages = sel_pages | tap_pages[i];
    end
    sel_end   = sel_start + span_of(sel_pages);
    last_step = ((CNT_W'(step_r) + CNT_W'(1)) == count_r);
  end

  // round the request up to pages and place it behind the tail, or one page above pool_base when the table is empty
  always_comb begin
    round_sum   = {1'b0, bytes_r} + (ADDR_W + 1)'(PAGE_BYTES - 1);
    round_pages = round_sum >> PAGE_SHIFT;
    alloc_pages = (round_pages > (ADDR_W + 1)'(PAGES_MAX)) ? PAGES_MAX
                                                          : round_pages[PAGES_W-1:0];
    alloc_addr  = (count_r == '0) ? (pool_base_r + ADDR_W'(PAGE_BYTES)) : tail_r;
    pool_end    = {1'b0, pool_base_r} + {1'b0, pool_bytes_r};
    alloc_ok    = (op_r == OP_ALLOC) && (bytes_r != '0) &&
                  (count_r != CNT_W'(MAX_ENTRIES));
    release_go  = (op_r == OP_RELEASE) && (count_r != '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXEC;
      S_EXEC: state_nxt = release_go ? S_WALK : S_DONE;
      S_WALK: if (last_step) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs: handshake and cell control
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    ctl.start    = (state_r == S_EXEC) && release_go;
    ctl.walk     = (state_r == S_WALK);
    ctl.run      = ctl.start | ctl.walk;
    ctl.shift    = found_r;
    ctl.wr_en    = (state_r == S_EXEC) && alloc_ok;
    ctl.target   = addr_r;
    ctl.wr_start = alloc_addr;
    ctl.wr_pages = alloc_pages;
    wr_idx       = count_r[IDX_W-1:0];
  end

  // table bookkeeping and result
  always_comb begin
    count_nxt      = count_r;
    tail_nxt       = tail_r;
    found_nxt      = found_r;
    hit_pages_nxt  = hit_pages_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_pages_nxt  = res_pages_r;
    res_inside_nxt = res_inside_r;
    case (state_r)
      S_EXEC: begin
        found_nxt      = 1'b0;
        res_status_nxt = ST_OK;
        res_addr_nxt   = '0;
        res_pages_nxt  = '0;
        res_inside_nxt = 1'b0;
        case (op_r)
          OP_ALLOC: begin
            if (bytes_r == '0) begin
              res_status_nxt = ST_ZERO;
            end else if (count_r == CNT_W'(MAX_ENTRIES)) begin
              res_status_nxt = ST_FULL;
            end else begin
              res_addr_nxt = alloc_addr;
              count_nxt    = count_r + CNT_W'(1);
              tail_nxt     = alloc_addr + span_of(alloc_pages);
            end
          end
          OP_RELEASE: begin
            if (count_r == '0) res_status_nxt = ST_MISSING;
          end
          OP_CHECK: begin
            res_inside_nxt = ({1'b0, addr_r} < pool_end) && (addr_r >= pool_base_r);
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (!found_r && any_match) begin
          found_nxt     = 1'b1;
          hit_pages_nxt = sel_pages;
        end
        if (last_step) begin
          if (found_nxt) begin
            count_nxt      = count_r - CNT_W'(1);
            res_pages_nxt  = found_r ? hit_pages_r : sel_pages;
            tail_nxt       = found_r ? sel_end : prev_end_r;
          end else begin
            res_status_nxt = ST_MISSING;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      pool_base_r  <= '0;
      pool_bytes_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_POOL_BASE:  pool_base_r  <= cfg_data;
          CFG_POOL_BYTES: pool_bytes_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // request capture, walk and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_op;
      bytes_r <= in_request_bytes;
      addr_r  <= in_target_address;
    end
    if (state_r == S_EXEC) begin
      step_r <= '0;
    end else if (state_r == S_WALK) begin
      step_r     <= step_r + IDX_W'(1);
      prev_end_r <= sel_end;
    end
    tail_r       <= tail_nxt;
    hit_pages_r  <= hit_pages_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_pages_r  <= res_pages_nxt;
    res_inside_r <= res_inside_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_pages_r  <= res_pages_r;
      out_inside_r <= res_inside_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_region_address = out_addr_r;
  assign out_released_pages = out_pages_r;
  assign out_inside_pool    = out_inside_r;

endmodule

// File: rtl/region_bump_allocator_unit.sv
// Top level of the region bump allocator: sequencer plus a chain of table cells.
// Depends on rba_pkg, rba_cell and rba_ctrl.
`timescale 1ns / 1ps

// Region bump allocator. Allocate places a page-rounded region one page above
// pool_base when the table is empty, otherwise directly behind the last region,
// and returns its base. Release finds the lowest entry with the exact base,
// returns its page count and closes the gap. Check tests an address against
// [pool_base, pool_base + pool_bytes). A release walks a token along the cell
// chain one entry per cycle while the entries behind the hit move down one
// place; allocate, check, unknown opcodes and a release on an empty table skip
// the walk. One request is in work at a time; the next request is taken while
// a result still waits in the output register. Reset empties the table;
// PAGE_BYTES must be a power of two.
module region_bump_allocator_unit #(
  parameter int MAX_ENTRIES = 32,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_target_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_region_address,
  output logic [20:0] out_released_pages,
  output logic        out_inside_pool
);
  import rba_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  cell_ctl_t          ctl;
  logic [IDX_W-1:0]   wr_idx;
  logic [MAX_ENTRIES-1:0] tok;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [ADDR_W-1:0]  cell_start [MAX_ENTRIES];
  logic [PAGES_W-1:0] cell_pages [MAX_ENTRIES];
  logic [ADDR_W-1:0]  tap_start  [MAX_ENTRIES];
  logic [PAGES_W-1:0] tap_pages  [MAX_ENTRIES];

  rba_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .PAGE_BYTES (PAGE_BYTES),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_request_bytes  (in_request_bytes),
    .in_target_address (in_target_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_region_address(out_region_address),
    .out_released_pages(out_released_pages),
    .out_inside_pool   (out_inside_pool),
    .ctl               (ctl),
    .wr_idx            (wr_idx),
    .match_vec         (match_vec),
    .tap_start         (tap_start),
    .tap_pages         (tap_pages)
  );

  // chain the table cells: token forward, entries pulled from the next cell
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic               tok_in;
    logic               nxt_tok;
    logic [ADDR_W-1:0]  nxt_start;
    logic [PAGES_W-1:0] nxt_pages;

    if (i == 0) begin : g_first
      assign tok_in = ctl.start;
    end else begin : g_mid
      assign tok_in = tok[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nxt_tok   = 1'b0;
      assign nxt_start = '0;
      assign nxt_pages = '0;
    end else begin : g_link
      assign nxt_tok   = tok[i+1];
      assign nxt_start = cell_start[i+1];
      assign nxt_pages = cell_pages[i+1];
    end

    rba_cell #(
      .IDX_W(IDX_W),
      .IDX  (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_idx   (wr_idx),
      .tok_in   (tok_in),
      .nxt_tok  (nxt_tok),
      .nxt_start(nxt_start),
      .nxt_pages(nxt_pages),
      .tok_out  (tok[i]),
      .start_out(cell_start[i]),
      .pages_out(cell_pages[i]),
      .match    (match_vec[i]),
      .tap_start(tap_start[i]),
      .tap_pages(tap_pages[i])
    );
  end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for region_bump_allocator_unit.
// Predicts every result from a local copy of the region table and pool settings.
// Depends on rba_pkg and the RTL of the allocator.
`timescale 1ns / 1ps

module testbench;
  import rba_pkg::*;

  localparam int MAX_ENTRIES = 32;
  localparam int PAGE_BYTES  = 4096;
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = MAX_ENTRIES + 8;

  typedef struct packed {
    status_t      status;
    logic [31:0]  region_address;
    logic [20:0]  released_pages;
    logic         inside_pool;
  } region_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [31:0] in_request_bytes = '0;
  logic [31:0] in_target_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_region_address;
  logic [20:0] out_released_pages;
  logic        out_inside_pool;

  // local copy of the allocator state
  logic [31:0] pool_base = '0;
  logic [31:0] pool_bytes = '0;
  logic [31:0] region_base [MAX_ENTRIES];
  logic [20:0] region_size [MAX_ENTRIES];
  int          region_total = 0;

  region_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int result_count = 0;
  int n_alloc = 0, n_zero = 0, n_full = 0;
  int n_release = 0, n_missing = 0;
  int n_check = 0, n_inside = 0, n_unknown = 0;

  region_bump_allocator_unit #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .PAGE_BYTES (PAGE_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_request_bytes  (in_request_bytes),
    .in_target_address (in_target_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_region_address(out_region_address),
    .out_released_pages(out_released_pages),
    .out_inside_pool   (out_inside_pool)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the result of one request and advance the local region table.
  function automatic region_result_t predict_region_op(input logic [1:0] op,
                                                       input logic [31:0] bytes,
                                                       input logic [31:0] addr);
    region_result_t res;
    logic [63:0]    page_cnt;
    logic [63:0]    next_base;
    logic [32:0]    pool_end;
    int             hit;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        n_alloc++;
        if (bytes == 32'd0) begin
          res.status = ST_ZERO;
          n_zero++;
        end else if (region_total >= MAX_ENTRIES) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          page_cnt = (64'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
          if (page_cnt > 64'(PAGES_MAX)) page_cnt = 64'(PAGES_MAX);
          // first region sits one page above the pool base, others follow the last
          if (region_total == 0) begin
            next_base = 64'(pool_base) + PAGE_BYTES;
          end else begin
            next_base = 64'(region_base[region_total-1])
                      + 64'(region_size[region_total-1]) * PAGE_BYTES;
          end
          region_base[region_total] = next_base[31:0];
          region_size[region_total] = page_cnt[20:0];
          region_total++;
          res.region_address = next_base[31:0];
        end
      end
      OP_RELEASE: begin
        n_release++;
        hit = -1;
        for (int i = 0; i < region_total; i++) begin
          if (hit < 0 && region_base[i] == addr) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISSING;
          n_missing++;
        end else begin
          res.released_pages = region_size[hit];
          // close the gap left by the released entry
          for (int i = hit; i + 1 < region_total; i++) begin
            region_base[i] = region_base[i+1];
            region_size[i] = region_size[i+1];
          end
          region_total--;
        end
      end
      OP_CHECK: begin
        n_check++;
        pool_end = {1'b0, pool_base} + {1'b0, pool_bytes};
        res.inside_pool = ({1'b0, addr} < pool_end) && (addr >= pool_base);
        if (res.inside_pool) n_inside++;
      end
      default: begin
        n_unknown++;
      end
    endcase
    return res;
  endfunction

  // Present one request, hold it until accepted and queue its expected result.
  task automatic send_request(input logic [1:0] op, input logic [31:0] bytes,
                              input logic [31:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_request_bytes  <= bytes;
    in_target_address <= addr;
    pending_results.push_back(predict_region_op(op, bytes, addr));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic settle_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reprogram the pool while the block is idle.
  task automatic set_pool(input logic [31:0] base, input logic [31:0] bytes);
    settle_results();
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_POOL_BASE;
    cfg_data     <= base;
    @(posedge clk);
    cfg_index    <= CFG_POOL_BYTES;
    cfg_data     <= bytes;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    pool_base  = base;
    pool_bytes = bytes;
  endtask

  // Release every live region in random order.
  task automatic empty_regions();
    while (region_total > 0) begin
      send_request(OP_RELEASE, $urandom, region_base[$urandom_range(0, region_total-1)]);
    end
  endtask

  task automatic test_directed_basics();
    logic [31:0] dup_base;
    set_pool(32'h1000_0000, 32'h0010_0000);
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_ALLOC, PAGE_BYTES, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, PAGE_BYTES + 1, 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    // a maximal region spans the whole address space, so the next one lands on it
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    dup_base = region_base[region_total-1];
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_RELEASE, 32'hFFFF_FFFF, dup_base);
    send_request(OP_RELEASE, 32'd0, dup_base);
    send_request(OP_RELEASE, 32'd0, dup_base);
    send_request(OP_RELEASE, 32'd0, region_base[0]);
    send_request(OP_RELEASE, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 32'hFFFF_FFFF, 32'h0FFF_FFFF);
    send_request(OP_CHECK, 32'd0, 32'h1000_0000);
    send_request(OP_CHECK, 32'd0, 32'h100F_FFFF);
    send_request(OP_CHECK, 32'd0, 32'h1010_0000);
    send_request(OP_CHECK, 32'd0, 32'h0000_0000);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_UNKNOWN, 32'd0, 32'd0);
    send_request(OP_ALLOC, 32'hFFFF_F001, 32'd0);
    send_request(OP_ALLOC, 32'h0000_1FFF, 32'd0);
  endtask

  task automatic test_pool_extremes();
    set_pool(32'h0000_0000, 32'h0000_0000);
    send_request(OP_CHECK, 32'd0, 32'h0000_0000);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_FFFF);
    // pool that reaches past the top of the address space
    set_pool(32'hFFFF_F000, 32'hFFFF_FFFF);
    empty_regions();
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_ALLOC, 32'h0000_2000, 32'd0);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_EFFF);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_F000);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 32'd0, 32'h0000_0000);
    // unaligned base
    set_pool(32'h1234_5678, 32'h0000_1000);
    send_request(OP_CHECK, 32'd0, 32'h1234_5677);
    send_request(OP_CHECK, 32'd0, 32'h1234_5678);
    send_request(OP_CHECK, 32'd0, 32'h1234_6677);
    send_request(OP_CHECK, 32'd0, 32'h1234_6678);
    empty_regions();
    send_request(OP_ALLOC, 32'd5, 32'd0);
    set_pool(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_FFFE);
    send_request(OP_CHECK, 32'd0, 32'h0000_0000);
  endtask

  task automatic test_table_full();
    empty_regions();
    while (region_total < MAX_ENTRIES) begin
      send_request(OP_ALLOC, $urandom_range(1, 4 * PAGE_BYTES), $urandom);
    end
    send_request(OP_ALLOC, $urandom_range(1, 32'hFFFF_FFFF), 32'd0);
    send_request(OP_ALLOC, 32'd0, 32'd0);
    send_request(OP_RELEASE, 32'd0, region_base[MAX_ENTRIES-1]);
    send_request(OP_ALLOC, 32'd1, 32'd0);
    send_request(OP_RELEASE, 32'd0, region_base[MAX_ENTRIES/2]);
    send_request(OP_RELEASE, 32'd0, region_base[0]);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_request(OP_ALLOC, 32'd7, 32'd0);
    send_request(OP_ALLOC, 32'd9, 32'd0);
  endtask

  // Mostly well-formed alloc/release traffic with checks, noise and bad releases.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int          pick;
    int          alloc_pct;
    logic [31:0] bytes;
    logic [31:0] addr;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // hold off once until the block has drained
      if (n == count / 2) settle_results();
      alloc_pct = (region_total < MAX_ENTRIES / 2) ? 45 : 30;
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        case ($urandom_range(0, 19))
          0:              bytes = 32'd0;
          1, 2, 3:        bytes = $urandom;
          4, 5:           bytes = $urandom_range(1, 8) * PAGE_BYTES + $urandom_range(0, 2) - 1;
          default:        bytes = $urandom_range(1, 8 * PAGE_BYTES);
        endcase
        send_request(OP_ALLOC, bytes, $urandom);
      end else if (pick < 75) begin
        if (region_total > 0 && $urandom_range(0, 9) < 8) begin
          addr = region_base[$urandom_range(0, region_total-1)];
        end else if ($urandom_range(0, 1) == 0) begin
          addr = $urandom;
        end else begin
          addr = region_base[$urandom_range(0, MAX_ENTRIES-1)] ^ (32'd1 << $urandom_range(0, 31));
          if (region_total == 0) addr = $urandom;
        end
        send_request(OP_RELEASE, $urandom, addr);
      end else if (pick < 95) begin
        case ($urandom_range(0, 5))
          0:       addr = pool_base - 1;
          1:       addr = pool_base;
          2:       addr = pool_base + pool_bytes - 1;
          3:       addr = pool_base + pool_bytes;
          4:       addr = pool_base + $urandom_range(0, 16 * PAGE_BYTES);
          default: addr = $urandom;
        endcase
        send_request(OP_CHECK, $urandom, addr);
      end else begin
        send_request(OP_UNKNOWN, $urandom, $urandom);
      end
    end
  endtask

  // Randomly stall the result channel.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    region_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] unexpected result: status %0d addr %h pages %0d inside %0b",
                   $realtime, out_status, out_region_address, out_released_pages,
                   out_inside_pool);
        end
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status ||
            out_region_address !== exp_res.region_address ||
            out_released_pages !== exp_res.released_pages ||
            out_inside_pool !== exp_res.inside_pool) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] result %0d mismatch: expected status %0d addr %h pages %0d inside %0b",
                     $realtime, result_count, exp_res.status, exp_res.region_address,
                     exp_res.released_pages, exp_res.inside_pool);
            $display("             got      status %0d addr %h pages %0d inside %0b",
                     out_status, out_region_address, out_released_pages, out_inside_pool);
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct  = 37;
    recv_stall_pct = 63;
    test_directed_basics();
    test_pool_extremes();
    test_table_full();
    set_pool({20'($urandom_range(0, 32'hF_FFFF)), 12'h000}, $urandom);
    test_random_traffic(560, 37, 63);
    set_pool(32'hFFFF_F000, 32'hFFFF_FFFF);
    test_random_traffic(560, 63, 37);
    set_pool($urandom, $urandom_range(0, 32 * PAGE_BYTES));
    test_random_traffic(560, 0, 0);
    settle_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d results: %0d allocations (%0d zero size, %0d table full),",
             result_count, n_alloc, n_zero, n_full);
    $display("%0d releases (%0d not found), %0d address checks (%0d inside), %0d unknown ops.",
             n_release, n_missing, n_check, n_inside, n_unknown);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
